// ===== rtl/cmsc_pkg.sv =====
package cmsc_pkg;

    localparam int WORD_W  = 64;
    localparam int MULT_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int IN_W    = 128;
    localparam int OUT_W   = 232;

    localparam int DEF_SAFE_SECONDS = 600;
    localparam int DEF_START_SHIFT  = 32;

    localparam logic [WORD_W-1:0] ALL_ONES  = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] NS_IN_SEC = 64'd1000000000;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 6'd32;

endpackage

// ===== rtl/cmsc_div.sv =====
module cmsc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cmsc_pkg::WORD_W-1:0] dividend,
    input  logic [cmsc_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [cmsc_pkg::WORD_W-1:0] quotient
);
    import cmsc_pkg::*;

    // restoring divider, one quotient bit per cycle
    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   trial_rem;
    logic [WORD_W:0]   diff;
    logic              ge;

    always_comb
    begin
        trial_rem = {rem_reg, quo_reg[WORD_W-1]};
        diff      = trial_rem - {1'b0, dvs_reg};
        ge        = ~diff[WORD_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = {CNT_W{1'b1}};
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WORD_W-1:0] : trial_rem[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/cmsc_mul.sv =====
module cmsc_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cmsc_pkg::WORD_W-1:0] mcand,
    input  logic [cmsc_pkg::MULT_W-1:0] mplier,
    output logic                       done,
    output logic [cmsc_pkg::WORD_W-1:0] product
);
    import cmsc_pkg::*;

    // shift-add multiplier, one multiplier bit per cycle, low word kept
    localparam int CNT_W = $clog2(MULT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] mcand_reg, mcand_next;
    logic [MULT_W-1:0] mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = {CNT_W{1'b1}};
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[WORD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MULT_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/counter_mult_shift_calibration.sv =====
// counter calibration: turns a counter frequency and wrap mask into a
// cycles-to-nanoseconds multiplier and shift plus the derived limits
// input stream (s_*): one transfer carries freq_hz and wrap_mask
// output stream (m_*): one transfer per input transfer carries valid_res, mult,
//   shift, overflow_cycles, unattended_ns and delta_limit
// rejected inputs (zero or too large frequency, bad mask) give valid_res = 0
//   and all other fields zero, with no multiply or divide run
// valid inputs run one bit-serial multiply, one bit-serial divide for the
//   safe bound, one trial divide per tried shift (up to 33 shifts) and,
//   unless the multiplier is zero, one divide for the overflow limit and
//   one multiply for the unattended time; all divides use the single shared
//   64-bit divider, which retires one bit a cycle
// one item at a time: s_tready is high only while the engine is idle
// a finished result sits in the output register; the next input is taken
//   while it waits, and its own result waits for the register to drain
// a stalled receiver holds m_tdata steady and only delays the next result
// reset empties the output register and returns the engine to idle
module counter_mult_shift_calibration #(
    parameter int SAFE_SECONDS = cmsc_pkg::DEF_SAFE_SECONDS,
    parameter int START_SHIFT  = cmsc_pkg::DEF_START_SHIFT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // freq_hz [63:0], wrap_mask [127:64]
    input  logic [cmsc_pkg::IN_W-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // valid_res [0], mult [32:1], shift [38:33], overflow_cycles [102:39],
    // unattended_ns [166:103], delta_limit [230:167], zero pad [231]
    output logic [cmsc_pkg::OUT_W-1:0] m_tdata
);
    import cmsc_pkg::*;

    // largest accepted frequency and the first shift to try
    localparam logic [WORD_W-1:0] HZ_MAX = ALL_ONES / 64'(SAFE_SECONDS);
    localparam int START_MOD = START_SHIFT % 64;
    localparam logic [SHIFT_W-1:0] SH_INIT =
        (START_MOD > 32) ? MAX_SHIFT : SHIFT_W'(START_MOD);
    localparam logic [WORD_W-1:0] NS_INIT = NS_IN_SEC << SH_INIT;

    // engine states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MSAFE = 3'd1;   // hz * safe seconds
    localparam logic [2:0] S_DSAFE = 3'd2;   // all ones / that product
    localparam logic [2:0] S_PREP  = 3'd3;   // build rounded numerator
    localparam logic [2:0] S_TRIAL = 3'd4;   // trial multiplier divide
    localparam logic [2:0] S_LIMIT = 3'd5;   // all ones / mult
    localparam logic [2:0] S_NS    = 3'd6;   // cycles * mult
    localparam logic [2:0] S_OUT   = 3'd7;   // wait for output register

    logic [2:0]         state_reg, state_next;
    logic [WORD_W-1:0]  hz_reg, hz_next;
    logic [WORD_W-1:0]  mask_reg, mask_next;
    logic [WORD_W-1:0]  safe_reg, safe_next;
    logic [SHIFT_W-1:0] sh_reg, sh_next;
    logic [WORD_W-1:0]  nssh_reg, nssh_next;
    logic [MULT_W-1:0]  mult_reg, mult_next;
    logic [WORD_W-1:0]  limit_reg, limit_next;
    logic [WORD_W-1:0]  ns_reg, ns_next;
    logic               ok_reg, ok_next;

    logic               div_start_reg, div_start_next;
    logic [WORD_W-1:0]  div_a_reg, div_a_next;
    logic [WORD_W-1:0]  div_b_reg, div_b_next;
    logic               mul_start_reg, mul_start_next;
    logic [WORD_W-1:0]  mul_a_reg, mul_a_next;
    logic [MULT_W-1:0]  mul_b_reg, mul_b_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic               div_done;
    logic [WORD_W-1:0]  div_quo;
    logic               mul_done;
    logic [WORD_W-1:0]  mul_prod;

    logic [WORD_W-1:0]  in_hz;
    logic [WORD_W-1:0]  in_mask;
    logic [WORD_W-1:0]  mask_plus;
    logic               in_ok;
    logic               trial_fits;
    logic [WORD_W-1:0]  min_lim;
    logic [WORD_W-1:0]  delta;

    cmsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    cmsc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    // input checks: nonzero, bounded frequency and a mask of low ones
    assign in_hz     = s_tdata[WORD_W-1:0];
    assign in_mask   = s_tdata[2*WORD_W-1:WORD_W];
    assign mask_plus = in_mask + 1'b1;
    assign in_ok     = (in_hz != '0) && (in_hz <= HZ_MAX) && (in_mask != '0)
                       && ((in_mask & mask_plus) == '0);

    assign trial_fits = (div_quo[WORD_W-1:MULT_W] == '0) && (div_quo <= safe_reg);
    assign min_lim    = (div_quo < mask_reg) ? div_quo : mask_reg;
    assign delta      = mask_reg - (mask_reg >> 3);

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        hz_next        = hz_reg;
        mask_next      = mask_reg;
        safe_next      = safe_reg;
        sh_next        = sh_reg;
        nssh_next      = nssh_reg;
        mult_next      = mult_reg;
        limit_next     = limit_reg;
        ns_next        = ns_reg;
        ok_next        = ok_reg;
        div_start_next = 1'b0;
        div_a_next     = div_a_reg;
        div_b_next     = div_b_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    hz_next   = in_hz;
                    mask_next = in_mask;
                    ok_next   = in_ok;
                    if (in_ok)
                    begin
                        mul_a_next     = in_hz;
                        mul_b_next     = MULT_W'(SAFE_SECONDS);
                        mul_start_next = 1'b1;
                        state_next     = S_MSAFE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MSAFE:
            begin
                if (mul_done)
                begin
                    div_a_next     = ALL_ONES;
                    div_b_next     = mul_prod;
                    div_start_next = 1'b1;
                    state_next     = S_DSAFE;
                end
            end
            S_DSAFE:
            begin
                if (div_done)
                begin
                    safe_next  = div_quo;
                    sh_next    = SH_INIT;
                    nssh_next  = NS_INIT;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // rounded numerator: (1e9 << shift) + hz / 2
                div_a_next     = nssh_reg + {1'b0, hz_reg[WORD_W-1:1]};
                div_b_next     = hz_reg;
                div_start_next = 1'b1;
                state_next     = S_TRIAL;
            end
            S_TRIAL:
            begin
                if (div_done)
                begin
                    if (trial_fits || (sh_reg == '0))
                    begin
                        mult_next = div_quo[MULT_W-1:0];
                        if (div_quo[MULT_W-1:0] == '0)
                        begin
                            // zero multiplier: saturated limit, no time
                            limit_next = ALL_ONES;
                            ns_next    = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            div_a_next     = ALL_ONES;
                            div_b_next     = {{(WORD_W-MULT_W){1'b0}}, div_quo[MULT_W-1:0]};
                            div_start_next = 1'b1;
                            state_next     = S_LIMIT;
                        end
                    end
                    else
                    begin
                        sh_next    = sh_reg - 1'b1;
                        nssh_next  = nssh_reg >> 1;
                        state_next = S_PREP;
                    end
                end
            end
            S_LIMIT:
            begin
                if (div_done)
                begin
                    limit_next     = div_quo;
                    mul_a_next     = min_lim >> 1;
                    mul_b_next     = mult_reg;
                    mul_start_next = 1'b1;
                    state_next     = S_NS;
                end
            end
            S_NS:
            begin
                if (mul_done)
                begin
                    ns_next    = mul_prod >> sh_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (ok_reg)
                    begin
                        m_tdata_next = {1'b0, delta, ns_reg, limit_reg, sh_reg,
                                        mult_reg, 1'b1};
                    end
                    else
                    begin
                        m_tdata_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            mul_start_reg <= mul_start_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hz_reg      <= hz_next;
        mask_reg    <= mask_next;
        safe_reg    <= safe_next;
        sh_reg      <= sh_next;
        nssh_reg    <= nssh_next;
        mult_reg    <= mult_next;
        limit_reg   <= limit_next;
        ns_reg      <= ns_next;
        ok_reg      <= ok_next;
        div_a_reg   <= div_a_next;
        div_b_reg   <= div_b_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== bench/counter_mult_shift_calibration_tb.sv =====
module counter_mult_shift_calibration_tb;

    // safe window and the frequency ceiling derived from it
    localparam logic [63:0] SAFE_SEC  = 64'(cmsc_pkg::DEF_SAFE_SECONDS);
    localparam logic [63:0] HZ_MAX    = cmsc_pkg::ALL_ONES / SAFE_SEC;
    localparam logic [63:0] LOW32     = 64'hFFFF_FFFF;
    localparam int          N_RANDOM  = 230;

    // stimulus shaping points, counted in accepted transfers; the receiver counts its quiet window in results
    localparam int HOLD_AT   = 40;    // receiver starts its long hold-off here
    localparam int HOLD_LEN  = 8000;  // long enough to fill engine and output register
    localparam int DRAIN_AT  = 80;    // sender waits here until every result is back
    localparam int QUIET_LO  = 130;   // no idling on either side in this window
    localparam int QUIET_HI  = 190;

    // tail wait, sized above the worst item time, and the watchdog limit
    localparam int TAIL_CYCLES = 2600;
    localparam int LIMIT       = 3_000_000;

    typedef struct packed {
        logic [63:0] hz;
        logic [63:0] mask;
    } freq_mask_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] mult;
        logic [5:0]  shift;
        logic [63:0] ovf_cycles;
        logic [63:0] unatt_ns;
        logic [63:0] delta_lim;
    } calib_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    // freq_hz [63:0], wrap_mask [127:64]
    logic [cmsc_pkg::IN_W-1:0]    s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // valid_res [0], mult [32:1], shift [38:33], overflow_cycles [102:39],
    // unattended_ns [166:103], delta_limit [230:167], zero pad [231]
    logic [cmsc_pkg::OUT_W-1:0]   m_tdata;

    freq_mask_t freq_mask_q[$];   // items waiting to be offered
    calib_t     calib_due_q[$];   // predicted results, oldest first

    int n_total   = 0;            // items queued for the whole run
    int n_taken   = 0;            // input transfers completed
    int n_out     = 0;            // output transfers seen
    int err_cnt   = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    counter_mult_shift_calibration u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // expected calibration for one frequency / mask pair
    function automatic calib_t predict_calib(input logic [63:0] hz, input logic [63:0] mask);
        calib_t      r;
        logic [63:0] safe_mult;
        logic [63:0] num;
        logic [63:0] trial;
        logic [63:0] mult64;
        logic [63:0] lim;
        logic [63:0] cyc;
        int unsigned sh;
        r = '0;
        // bad frequency or mask: flag clear, everything else zero
        if (hz == 64'd0 || hz > HZ_MAX)
            return r;
        if (mask == 64'd0 || (mask & (mask + 64'd1)) != 64'd0)
            return r;
        safe_mult = cmsc_pkg::ALL_ONES / (hz * SAFE_SEC);
        sh = cmsc_pkg::DEF_START_SHIFT & 63;
        if (sh > 32)
            sh = 32;
        // walk the shift down until the rounded multiplier fits both bounds
        forever
        begin
            num   = (cmsc_pkg::NS_IN_SEC << sh) + (hz >> 1);
            trial = num / hz;
            if ((trial <= LOW32 && trial <= safe_mult) || sh == 0)
                break;
            sh--;
        end
        mult64 = trial & LOW32;
        if (mult64 == 64'd0)
        begin
            // zero multiplier saturates the cycle limit
            lim            = cmsc_pkg::ALL_ONES;
            r.unatt_ns     = 64'd0;
        end
        else
        begin
            lim        = cmsc_pkg::ALL_ONES / mult64;
            cyc        = ((lim < mask) ? lim : mask) >> 1;
            r.unatt_ns = (cyc * mult64) >> sh;
        end
        r.ok         = 1'b1;
        r.mult       = mult64[31:0];
        r.shift      = sh[5:0];
        r.ovf_cycles = lim;
        r.delta_lim  = mask - (mask >> 3);
        return r;
    endfunction

    // random pair: mostly well-formed frequencies and contiguous masks
    function automatic freq_mask_t rand_freq_mask();
        freq_mask_t  it;
        logic [63:0] r64;
        int          pick;
        r64  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.hz = r64;                              // mostly too large
        else if (pick < 14)
            it.hz = 64'($urandom_range(1, 1000));     // deep shift search
        else
        begin
            it.hz = r64 >> $urandom_range(10, 63);    // log spread, always in range
            if (it.hz == 64'd0)
                it.hz = 64'd1;
        end
        r64  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.mask = r64;
        else if (pick < 10)
            it.mask = 64'd0;
        else if (pick < 14)
            it.mask = (cmsc_pkg::ALL_ONES >> $urandom_range(0, 63))
                      ^ (64'd1 << $urandom_range(0, 63));
        else
            it.mask = cmsc_pkg::ALL_ONES >> $urandom_range(0, 63);
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("mismatch at result %0d: %s", n_out, msg);
    endtask

    task automatic queue_item(input logic [63:0] hz, input logic [63:0] mask);
        freq_mask_q.push_back('{hz: hz, mask: mask});
        n_total++;
    endtask

    // sender: presents queued items, idles at random, pauses once for a drain
    always @(posedge clk or negedge rst_n)
    begin
        freq_mask_t nxt;
        bit         offer;
        int         taken_now;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            taken_now = n_taken + ((s_tvalid && s_tready) ? 1 : 0);
            n_taken  <= taken_now;
            // an offered item stays put until its transfer completes
            if (!(s_tvalid && !s_tready))
            begin
                offer = (freq_mask_q.size() != 0);
                if (taken_now == DRAIN_AT && taken_now != n_out)
                    offer = 1'b0;
                if ((taken_now < QUIET_LO || taken_now >= QUIET_HI)
                    && $urandom_range(0, 99) < 15)
                    offer = 1'b0;
                if (offer)
                begin
                    nxt = freq_mask_q.pop_front();
                    s_tdata <= {nxt.mask, nxt.hz};
                end
                s_tvalid <= offer;
            end
        end
    end

    // receiver: random back-pressure, one long hold-off and an always-ready window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && n_taken >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else if (n_out >= QUIET_LO && n_out < QUIET_HI)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 15);
    end

    // monitor: predicts on each input transfer, checks each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        calib_t got;
        calib_t want;
        if (!rst_n)
            n_out <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.ok         = m_tdata[0];
                got.mult       = m_tdata[32:1];
                got.shift      = m_tdata[38:33];
                got.ovf_cycles = m_tdata[102:39];
                got.unatt_ns   = m_tdata[166:103];
                got.delta_lim  = m_tdata[230:167];
                if (calib_due_q.size() == 0)
                    report_mismatch("result with nothing pending");
                else
                begin
                    want = calib_due_q.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("valid_res got %b want %b", got.ok, want.ok));
                    if (got.mult !== want.mult)
                        report_mismatch($sformatf("mult got %h want %h", got.mult, want.mult));
                    if (got.shift !== want.shift)
                        report_mismatch($sformatf("shift got %0d want %0d",
                                                  got.shift, want.shift));
                    if (got.ovf_cycles !== want.ovf_cycles)
                        report_mismatch($sformatf("overflow_cycles got %h want %h",
                                                  got.ovf_cycles, want.ovf_cycles));
                    if (got.unatt_ns !== want.unatt_ns)
                        report_mismatch($sformatf("unattended_ns got %h want %h",
                                                  got.unatt_ns, want.unatt_ns));
                    if (got.delta_lim !== want.delta_lim)
                        report_mismatch($sformatf("delta_limit got %h want %h",
                                                  got.delta_lim, want.delta_lim));
                end
                n_out <= n_out + 1;
            end
            if (s_tvalid && s_tready)
                calib_due_q.push_back(predict_calib(s_tdata[63:0], s_tdata[127:64]));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        // directed: validation edges and typical counters
        queue_item(64'd0, LOW32);                                 // zero frequency
        queue_item(64'd1, cmsc_pkg::ALL_ONES);                    // slowest counter
        queue_item(HZ_MAX, 64'd1);                                // fastest allowed, 1-bit mask
        queue_item(HZ_MAX + 64'd1, cmsc_pkg::ALL_ONES);           // just too fast
        queue_item(cmsc_pkg::ALL_ONES, cmsc_pkg::ALL_ONES);
        queue_item(64'd32768, 64'd0);                             // zero mask
        queue_item(64'd32768, 64'h5);                             // holes in mask
        queue_item(64'd32768, 64'h8000_0000_0000_0000);           // top bit only
        queue_item(64'd32768, LOW32);
        queue_item(64'd1_000_000, 64'h00FF_FFFF_FFFF_FFFF);
        queue_item(64'd19_200_000, 64'h00FF_FFFF_FFFF_FFFF);
        queue_item(64'd24_000_000, cmsc_pkg::ALL_ONES);
        queue_item(64'd1_000_000_000, LOW32);
        queue_item(64'd3_000_000_000, cmsc_pkg::ALL_ONES);
        queue_item(64'd1 << 40, 64'h0000_00FF_FFFF_FFFF);
        queue_item(64'd2, 64'h3);
        queue_item(64'd1000, cmsc_pkg::ALL_ONES >> 1);
        queue_item(HZ_MAX, cmsc_pkg::ALL_ONES);
        queue_item(64'h5555_5555_5555, cmsc_pkg::ALL_ONES ^ 64'd1);
        queue_item(64'd999_999_999_999, 64'hFFFF);
        queue_item(HZ_MAX - 64'd1, 64'h7FFF_FFFF);
        repeat (N_RANDOM)
            freq_mask_q.push_back(rand_freq_mask());
        n_total += N_RANDOM;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_out < n_total)
            @(posedge clk);
        // stray results would show up within one more item time
        repeat (TAIL_CYCLES) @(posedge clk);
        if (calib_due_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", calib_due_q.size()));

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
